>>> hdl/fir_filter_top_defines.svh
// ============================================================================
// fir_filter_top_defines.svh
// Assertion macros for the FIR filter block.
// ============================================================================
`ifndef FIR_FILTER_TOP_DEFINES_SVH
`define FIR_FILTER_TOP_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define FIR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define FIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/fir_pkg.sv
// ============================================================================
// fir_pkg
// Types and constants shared by the FIR filter modules.
// ============================================================================
package fir_pkg;

    localparam int MAX_TAPS        = 128;
    localparam int SAMPLE_WIDTH    = 16;
    localparam int COEF_WIDTH      = 16;
    localparam int ACC_WIDTH       = 40;
    localparam int TAP_COUNT_W     = 8;
    localparam int COEF_IDX_W      = 7;
    localparam int TAP_IDX_W       = $clog2(MAX_TAPS);
    localparam int TAP_COUNT_RESET = 101;
    localparam int CMD_DEPTH       = 4;
    localparam int CMD_PTR_W       = $clog2(CMD_DEPTH);

    typedef enum logic [1:0] {
        OP_FILTER = 2'd0,
        OP_LOAD   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CMD_FILTER = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } back_state_t;

    typedef struct packed {
        op_t                            op;
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic [COEF_IDX_W-1:0]          coef_index;
        logic signed [COEF_WIDTH-1:0]   coef_value;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] filtered;
        logic                           saturated;
    } out_item_t;

    typedef struct packed {
        cmd_kind_t                      kind;
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic signed [COEF_WIDTH-1:0]   coef;
        logic [TAP_IDX_W-1:0]           addr;
    } cmd_entry_t;

    typedef struct packed {
        logic       valid;
        cmd_entry_t cmd;
    } front_wr_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic pop;
        logic finishing;
    } back_stat_t;

endpackage

>>> hdl/fir_front.sv
// ============================================================================
// fir_front
// Accepts input items, drops ignored ones and forms queue commands.
// ============================================================================
module fir_front (
    input  logic               push,
    input  fir_pkg::in_item_t  item,
    input  fir_pkg::fifo_stat_t q_stat,
    output fir_pkg::front_wr_t wr
);

    function automatic logic [fir_pkg::TAP_IDX_W-1:0] tap_addr(
        input logic [fir_pkg::COEF_IDX_W-1:0] idx
    );
        logic [31:0] w;
        w = 32'(idx);
        return w[fir_pkg::TAP_IDX_W-1:0];
    endfunction

    logic keep;

    always_comb
    begin
        keep          = 1'b0;
        wr.cmd.kind   = fir_pkg::CMD_FILTER;
        wr.cmd.sample = item.sample;
        wr.cmd.coef   = item.coef_value;
        wr.cmd.addr   = tap_addr(item.coef_index);
        unique case (item.op)
            fir_pkg::OP_FILTER:
            begin
                keep        = 1'b1;
                wr.cmd.kind = fir_pkg::CMD_FILTER;
            end
            fir_pkg::OP_LOAD:
            begin
                keep        = (32'(item.coef_index) < fir_pkg::MAX_TAPS);
                wr.cmd.kind = fir_pkg::CMD_LOAD;
            end
            fir_pkg::OP_CLEAR:
            begin
                keep        = 1'b1;
                wr.cmd.kind = fir_pkg::CMD_CLEAR;
            end
            fir_pkg::OP_NOP:
            begin
                keep = 1'b0;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
        wr.valid = push && !q_stat.full && keep;
    end

endmodule

>>> hdl/fir_cmd_fifo.sv
// ============================================================================
// fir_cmd_fifo
// Short command queue between the front and the MAC engine.
// ============================================================================
module fir_cmd_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fir_pkg::front_wr_t   wr,
    input  logic                 rd,
    output fir_pkg::cmd_entry_t  head,
    output fir_pkg::fifo_stat_t  stat
);

    fir_pkg::cmd_entry_t            mem_reg [fir_pkg::CMD_DEPTH];
    logic [fir_pkg::CMD_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [fir_pkg::CMD_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [fir_pkg::CMD_PTR_W:0]    count_reg, count_next;
    logic                           do_wr, do_rd;

    assign stat.full  = (count_reg == (fir_pkg::CMD_PTR_W+1)'(fir_pkg::CMD_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr.valid && !stat.full;
    assign do_rd      = rd && !stat.empty;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == fir_pkg::CMD_PTR_W'(fir_pkg::CMD_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == fir_pkg::CMD_PTR_W'(fir_pkg::CMD_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr.cmd;
        end
    end

endmodule

>>> hdl/fir_back.sv
// ============================================================================
// fir_back
// MAC engine: tap and history stores, shared multiply-accumulate,
// rounding, saturation and the result register.
// ============================================================================
module fir_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fir_pkg::TAP_COUNT_W-1:0] cfg_data,
    input  fir_pkg::cmd_entry_t           cmd,
    input  fir_pkg::fifo_stat_t           q_stat,
    output fir_pkg::back_stat_t           stat,
    input  logic                          pop,
    output logic                          empty,
    output fir_pkg::out_item_t            result
);

    localparam int PROD_W = fir_pkg::SAMPLE_WIDTH + fir_pkg::COEF_WIDTH;
    localparam int RND_W  = fir_pkg::ACC_WIDTH + 1;
    localparam int R_W    = RND_W - (fir_pkg::COEF_WIDTH - 1);
    localparam int IW     = fir_pkg::TAP_IDX_W;
    localparam logic [RND_W-1:0] RND_HALF = RND_W'(1) << (fir_pkg::COEF_WIDTH - 2);

    fir_pkg::back_state_t state_reg, state_next;

    logic [fir_pkg::TAP_COUNT_W-1:0]  tap_count_reg;
    logic [IW-1:0]                    head_reg, base_reg, m_reg, last_reg;
    logic                             rd_vld_reg, mul_vld_reg;
    logic [fir_pkg::MAX_TAPS-1:0]     tap_vld_reg, hist_vld_reg;
    logic [fir_pkg::COEF_WIDTH-1:0]   tap_mem [fir_pkg::MAX_TAPS];
    logic [fir_pkg::SAMPLE_WIDTH-1:0] hist_mem [fir_pkg::MAX_TAPS];
    logic [fir_pkg::COEF_WIDTH-1:0]   tap_rd_reg;
    logic [fir_pkg::SAMPLE_WIDTH-1:0] hist_rd_reg;
    logic                             tap_ok_reg, hist_ok_reg;
    logic signed [PROD_W-1:0]         prod_reg;
    logic [fir_pkg::ACC_WIDTH-1:0]    acc_reg;
    logic                             out_vld_reg;
    fir_pkg::out_item_t               out_reg;

    logic cmd_pop, hist_we, tap_we, hist_clr, start, rd_en, out_load, last_issue;
    logic [IW:0]                      slot_w;
    logic [IW-1:0]                    hist_addr, last_eff;
    logic [31:0]                      tc32;
    logic signed [fir_pkg::COEF_WIDTH-1:0]   tap_q;
    logic signed [fir_pkg::SAMPLE_WIDTH-1:0] hist_q;
    logic signed [PROD_W-1:0]         prod;
    logic [RND_W-1:0]                 rnd_sum;
    logic [R_W-1:0]                   r;
    logic                             ovf;
    fir_pkg::out_item_t               out_calc;

    // history slot of tap m: base - m modulo MAX_TAPS
    always_comb
    begin
        slot_w = {1'b0, base_reg} - {1'b0, m_reg};
        if (base_reg < m_reg)
        begin
            slot_w = slot_w + (IW+1)'(fir_pkg::MAX_TAPS);
        end
        hist_addr = slot_w[IW-1:0];
    end

    always_comb
    begin
        tc32 = 32'(tap_count_reg);
        if (tc32 == 32'd0)
        begin
            last_eff = '0;
        end
        else if (tc32 > fir_pkg::MAX_TAPS)
        begin
            last_eff = IW'(fir_pkg::MAX_TAPS - 1);
        end
        else
        begin
            last_eff = IW'(tc32 - 32'd1);
        end
    end

    assign last_issue = (m_reg == last_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fir_pkg::ST_IDLE:
            begin
                if (!q_stat.empty && cmd.kind == fir_pkg::CMD_FILTER)
                begin
                    state_next = fir_pkg::ST_RUN;
                end
            end
            fir_pkg::ST_RUN:
            begin
                if (last_issue)
                begin
                    state_next = fir_pkg::ST_DRAIN;
                end
            end
            fir_pkg::ST_DRAIN:
            begin
                if (!rd_vld_reg && !mul_vld_reg)
                begin
                    state_next = fir_pkg::ST_FINISH;
                end
            end
            fir_pkg::ST_FINISH:
            begin
                if (!out_vld_reg || pop)
                begin
                    state_next = fir_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fir_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd_pop  = 1'b0;
        hist_we  = 1'b0;
        tap_we   = 1'b0;
        hist_clr = 1'b0;
        start    = 1'b0;
        rd_en    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            fir_pkg::ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind)
                        fir_pkg::CMD_FILTER:
                        begin
                            hist_we = 1'b1;
                            start   = 1'b1;
                        end
                        fir_pkg::CMD_LOAD:
                        begin
                            tap_we = 1'b1;
                        end
                        fir_pkg::CMD_CLEAR:
                        begin
                            hist_clr = 1'b1;
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            fir_pkg::ST_RUN:
            begin
                rd_en = 1'b1;
            end
            fir_pkg::ST_DRAIN:
            begin
                rd_en = 1'b0;
            end
            fir_pkg::ST_FINISH:
            begin
                out_load = !out_vld_reg || pop;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign stat.pop       = cmd_pop;
    assign stat.finishing = (state_reg == fir_pkg::ST_FINISH);

    // invalid entries read as zero
    assign tap_q  = tap_ok_reg  ? $signed(tap_rd_reg)  : '0;
    assign hist_q = hist_ok_reg ? $signed(hist_rd_reg) : '0;
    assign prod   = tap_q * hist_q;

    // round to nearest, ties up, then saturate
    always_comb
    begin
        rnd_sum = {acc_reg[fir_pkg::ACC_WIDTH-1], acc_reg} + RND_HALF;
        r       = rnd_sum[RND_W-1:fir_pkg::COEF_WIDTH-1];
        ovf     = !((&r[R_W-1:fir_pkg::SAMPLE_WIDTH-1]) ||
                    (~|r[R_W-1:fir_pkg::SAMPLE_WIDTH-1]));
        out_calc.saturated = ovf;
        if (ovf)
        begin
            out_calc.filtered = r[R_W-1] ?
                {1'b1, {(fir_pkg::SAMPLE_WIDTH-1){1'b0}}} :
                {1'b0, {(fir_pkg::SAMPLE_WIDTH-1){1'b1}}};
        end
        else
        begin
            out_calc.filtered = r[fir_pkg::SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fir_pkg::ST_IDLE;
            tap_count_reg <= fir_pkg::TAP_COUNT_W'(fir_pkg::TAP_COUNT_RESET);
            head_reg      <= '0;
            base_reg      <= '0;
            m_reg         <= '0;
            last_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            mul_vld_reg   <= 1'b0;
            tap_vld_reg   <= '0;
            hist_vld_reg  <= '0;
            acc_reg       <= '0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_vld_reg  <= rd_en;
            mul_vld_reg <= rd_vld_reg;
            if (cfg_we)
            begin
                tap_count_reg <= cfg_data;
            end
            if (tap_we)
            begin
                tap_vld_reg[cmd.addr] <= 1'b1;
            end
            if (hist_clr)
            begin
                hist_vld_reg <= '0;
                head_reg     <= '0;
            end
            else if (hist_we)
            begin
                hist_vld_reg[head_reg] <= 1'b1;
                head_reg <= (head_reg == IW'(fir_pkg::MAX_TAPS - 1)) ? '0 : head_reg + 1'b1;
            end
            if (start)
            begin
                base_reg <= head_reg;
                m_reg    <= '0;
                last_reg <= last_eff;
                acc_reg  <= '0;
            end
            else
            begin
                if (rd_en)
                begin
                    m_reg <= m_reg + 1'b1;
                end
                if (mul_vld_reg)
                begin
                    acc_reg <= acc_reg +
                        {{(fir_pkg::ACC_WIDTH-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
                end
            end
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tap_we)
        begin
            tap_mem[cmd.addr] <= cmd.coef;
        end
        tap_rd_reg <= tap_mem[m_reg];
        tap_ok_reg <= tap_vld_reg[m_reg];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[head_reg] <= cmd.sample;
        end
        hist_rd_reg <= hist_mem[hist_addr];
        hist_ok_reg <= hist_vld_reg[hist_addr];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        if (out_load)
        begin
            out_reg <= out_calc;
        end
    end

    assign empty  = !out_vld_reg;
    assign result = out_reg;

endmodule

>>> hdl/fir_filter_top.sv
// ============================================================================
// fir_filter_top
// Direct-form FIR filter, Q1.15 data, 40-bit accumulation, up to 128 taps.
// Input queue side: item with push/full; transfer when push and not full.
// Result queue side: result with empty/pop; transfer when pop and not empty.
// op filter yields one result; coefficient load, history clear and the
// unused op code yield none. cfg_we writes tap_count from cfg_data.
// In the MAC engine a sample (T = taps in use, 1..128) passes through one
// history write, T reads through the single shared multiply-accumulate, a
// pipeline drain and a rounding step. Loads and clears are done as the
// command is popped. A four-entry command queue decouples the input side.
// Reset clears the history, the coefficients (both read as zero) and sets
// tap_count to 101. If the result is not popped, the engine holds its next
// result in its finish (rounding) state; the queue then fills and full rises.
// ============================================================================
`include "fir_filter_top_defines.svh"

module fir_filter_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  fir_pkg::in_item_t               item,
    output logic                            empty,
    input  logic                            pop,
    output fir_pkg::out_item_t              result,
    input  logic                            cfg_we,
    input  logic [fir_pkg::TAP_COUNT_W-1:0] cfg_data
);

    fir_pkg::front_wr_t  fe_wr;
    fir_pkg::fifo_stat_t q_stat;
    fir_pkg::cmd_entry_t q_head;
    fir_pkg::back_stat_t be_stat;

    assign full = q_stat.full;

    fir_front u_front (
        .push   (push),
        .item   (item),
        .q_stat (q_stat),
        .wr     (fe_wr)
    );

    fir_cmd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (fe_wr),
        .rd    (be_stat.pop),
        .head  (q_head),
        .stat  (q_stat)
    );

    fir_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (q_head),
        .q_stat   (q_stat),
        .stat     (be_stat),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

    `FIR_ASSERT_NOW(a_no_write_when_full, fe_wr.valid, !q_stat.full, "write into full queue")
    `FIR_ASSERT_NOW(a_no_pop_when_empty, be_stat.pop, !q_stat.empty, "pop from empty queue")
    `FIR_ASSERT_NOW(a_result_from_finish, $fell(empty), $past(be_stat.finishing), "stray result")

endmodule
